>>> hdl/swdse_pkg.sv
// Shared types and constants for the SWD sequence engine.
// No dependencies; imported by every module of the block.
package swdse_pkg;

	localparam int MAX_SEQ_CYCLES = 64;

	localparam logic [1:0] PH_COUNT = 2'd0;
	localparam logic [1:0] PH_INFO  = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;
	localparam logic [1:0] PH_READ  = 2'd3;

	localparam logic [1:0] KIND_DRIVE  = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_BYTE   = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	// Results one input beat causes, emitted in this order.
	typedef struct packed {
		logic [3:0] n_drive;
		logic [3:0] n_zero;
		logic       has_byte;
		logic       has_sample;
		logic       has_status;
	} plan_t;

	typedef struct packed {
		logic       accept;
		logic       load;
		logic [1:0] kind;
		logic       last;
	} cmd_t;

endpackage

>>> hdl/swdse_ctrl.sv
// Controller: input handshake, result sequencing and output valid.
// Depends on swdse_pkg.
module swdse_ctrl
	import swdse_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  plan_t plan,
	output cmd_t  cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic       state_q;
	logic       out_valid_q;
	logic [3:0] nd_q;
	logic [3:0] nz_q;
	logic       pb_q;
	logic       ps_q;
	logic       pst_q;
	logic [3:0] nd_n;
	logic [3:0] nz_n;
	logic       pb_n;
	logic       ps_n;
	logic       pst_n;
	logic       plan_any;

	assign plan_any  = (plan.n_drive != 4'd0) || (plan.n_zero != 4'd0) || plan.has_byte
		|| plan.has_sample || plan.has_status;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		nd_n  = nd_q;
		nz_n  = nz_q;
		pb_n  = pb_q;
		ps_n  = ps_q;
		pst_n = pst_q;
		cmd.accept = in_valid && in_ready;
		cmd.load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		if (nd_q != 4'd0) begin
			cmd.kind = KIND_DRIVE;
			nd_n = nd_q - 4'd1;
		end else if (nz_q != 4'd0) begin
			cmd.kind = KIND_BYTE;
			nz_n = nz_q - 4'd1;
		end else if (pb_q) begin
			cmd.kind = KIND_BYTE;
			pb_n = 1'b0;
		end else if (ps_q) begin
			cmd.kind = KIND_SAMPLE;
			ps_n = 1'b0;
		end else begin
			cmd.kind = KIND_STATUS;
			pst_n = 1'b0;
		end
		cmd.last = (nd_n == 4'd0) && (nz_n == 4'd0) && !pb_n && !ps_n && !pst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			nd_q        <= 4'd0;
			nz_q        <= 4'd0;
			pb_q        <= 1'b0;
			ps_q        <= 1'b0;
			pst_q       <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept && plan_any) begin
						state_q <= ST_EMIT;
						nd_q    <= plan.n_drive;
						nz_q    <= plan.n_zero;
						pb_q    <= plan.has_byte;
						ps_q    <= plan.has_sample;
						pst_q   <= plan.has_status;
					end
				end
				ST_EMIT: begin
					if (cmd.load) begin
						nd_q  <= nd_n;
						nz_q  <= nz_n;
						pb_q  <= pb_n;
						ps_q  <= ps_n;
						pst_q <= pst_n;
						if (cmd.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hdl/swdse_dp.sv
// Datapath: parse state, capture shifter, drive shifter and result register.
// Depends on swdse_pkg.
module swdse_dp
	import swdse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       command,
	input  logic [7:0] request_byte,
	input  logic       line_level,
	input  cmd_t       cmd,
	output plan_t      plan,
	output logic [1:0] kind,
	output logic       line_bit,
	output logic [7:0] data_byte,
	output logic       status,
	output logic       last
);

	logic       swd_q;
	logic [1:0] phase_q;
	logic [7:0] seq_q;
	logic [6:0] cyc_q;
	logic [7:0] cap_q;
	logic [3:0] bits_q;
	logic       rmode_q;
	logic       err_q;
	logic [1:0] phase_d;
	logic [7:0] seq_d;
	logic [6:0] cyc_d;
	logic [7:0] cap_d;
	logic [3:0] bits_d;
	logic       rmode_d;
	logic       err_d;
	logic [7:0] rbyte_d;
	logic       stat_d;
	logic [6:0] cyc_info;
	logic [6:0] nb_wide;
	logic [3:0] wr_cnt;
	logic [7:0] cap_n;
	logic [3:0] bits_n;
	logic [6:0] cyc_dec;
	logic [2:0] sh;
	logic       fin_seq;
	logic       fin_cmd;
	logic [7:0] drv_q;
	logic [7:0] rbyte_q;
	logic       stat_q;
	logic [1:0] kind_q;
	logic       line_bit_q;
	logic [7:0] data_q;
	logic       status_q;
	logic       last_q;

	always_comb begin
		phase_d = phase_q;
		seq_d   = seq_q;
		cyc_d   = cyc_q;
		cap_d   = cap_q;
		bits_d  = bits_q;
		rmode_d = rmode_q;
		err_d   = err_q;
		rbyte_d = 8'h00;
		stat_d  = 1'b0;
		plan    = '0;
		fin_seq = 1'b0;
		fin_cmd = 1'b0;
		cyc_info = (request_byte[5:0] == 6'd0) ? 7'd64 : {1'b0, request_byte[5:0]};
		if (cyc_info > 7'(MAX_SEQ_CYCLES)) begin
			cyc_info = 7'(MAX_SEQ_CYCLES);
		end
		nb_wide = (cyc_info + 7'd7) >> 3;
		wr_cnt  = (cyc_q < 7'd8) ? cyc_q[3:0] : 4'd8;
		cap_n   = {line_level, cap_q[7:1]};
		bits_n  = bits_q + 4'd1;
		cyc_dec = (cyc_q != 7'd0) ? cyc_q - 7'd1 : cyc_q;
		sh      = 3'(4'd8 - bits_n);
		if (!command) begin
			case (phase_q)
				PH_COUNT: begin
					seq_d = request_byte;
					if (request_byte == 8'd0) begin
						fin_cmd = 1'b1;
					end else begin
						phase_d = PH_INFO;
					end
				end
				PH_INFO: begin
					rmode_d = request_byte[7];
					cyc_d   = cyc_info;
					cap_d   = 8'h00;
					bits_d  = 4'd0;
					if (!swd_q) begin
						err_d = 1'b1;
						if (request_byte[7]) begin
							plan.n_zero = nb_wide[3:0];
							fin_seq     = 1'b1;
						end else begin
							phase_d = PH_WRITE;
						end
					end else if (request_byte[7]) begin
						phase_d         = PH_READ;
						plan.has_sample = 1'b1;
					end else begin
						phase_d = PH_WRITE;
					end
				end
				PH_WRITE: begin
					if (swd_q) begin
						plan.n_drive = wr_cnt;
					end else begin
						err_d = 1'b1;
					end
					cyc_d = cyc_q - {3'b000, wr_cnt};
					if (cyc_d == 7'd0) begin
						fin_seq = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (phase_q == PH_READ) begin
			cap_d  = cap_n;
			bits_d = bits_n;
			cyc_d  = cyc_dec;
			if (bits_n >= 4'd8 || cyc_dec == 7'd0) begin
				plan.has_byte = 1'b1;
				rbyte_d       = cap_n >> sh;
				cap_d         = 8'h00;
				bits_d        = 4'd0;
			end
			if (cyc_dec != 7'd0) begin
				plan.has_sample = 1'b1;
			end else begin
				fin_seq = 1'b1;
			end
		end
		if (fin_seq) begin
			seq_d  = seq_q - 8'd1;
			cyc_d  = 7'd0;
			cap_d  = 8'h00;
			bits_d = 4'd0;
			if (seq_d == 8'd0) begin
				fin_cmd = 1'b1;
			end else begin
				phase_d = PH_INFO;
			end
		end
		if (fin_cmd) begin
			plan.has_status = 1'b1;
			stat_d  = err_d;
			err_d   = 1'b0;
			phase_d = PH_COUNT;
			cyc_d   = 7'd0;
			cap_d   = 8'h00;
			bits_d  = 4'd0;
			rmode_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swd_q   <= 1'b0;
			phase_q <= PH_COUNT;
			seq_q   <= 8'd0;
			cyc_q   <= 7'd0;
			cap_q   <= 8'h00;
			bits_q  <= 4'd0;
			rmode_q <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				swd_q <= cfg_wr_data;
			end
			if (cmd.accept) begin
				phase_q <= phase_d;
				seq_q   <= seq_d;
				cyc_q   <= cyc_d;
				cap_q   <= cap_d;
				bits_q  <= bits_d;
				rmode_q <= rmode_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			drv_q   <= request_byte;
			rbyte_q <= rbyte_d;
			stat_q  <= stat_d;
		end else if (cmd.load && cmd.kind == KIND_DRIVE) begin
			drv_q <= {1'b0, drv_q[7:1]};
		end
		if (cmd.load) begin
			kind_q     <= cmd.kind;
			last_q     <= cmd.last;
			line_bit_q <= (cmd.kind == KIND_DRIVE) ? drv_q[0] : 1'b0;
			data_q     <= (cmd.kind == KIND_BYTE) ? rbyte_q : 8'h00;
			status_q   <= (cmd.kind == KIND_STATUS) ? stat_q : 1'b0;
		end
	end

	assign kind      = kind_q;
	assign line_bit  = line_bit_q;
	assign data_byte = data_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

>>> hdl/swd_sequence_engine.sv
// SWD sequence engine top level: controller plus datapath.
// An input beat yields up to nine results, one per cycle while out_ready does not
// stall the output, and the next beat is taken the cycle after the last of them
// is loaded.
// Reset (arst_n, asynchronous): parser expects a sequence count, port not SWD.
// Depends on swdse_pkg, swdse_ctrl, swdse_dp.
module swd_sequence_engine
	import swdse_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] request_byte,
	input  logic       line_level,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic       line_bit,
	output logic [7:0] data_byte,
	output logic       status,
	output logic       last
);

	plan_t plan;
	cmd_t  cmd;

	swdse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.plan      (plan),
		.cmd       (cmd)
	);

	swdse_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.command      (command),
		.request_byte (request_byte),
		.line_level   (line_level),
		.cmd          (cmd),
		.plan         (plan),
		.kind         (kind),
		.line_bit     (line_bit),
		.data_byte    (data_byte),
		.status       (status),
		.last         (last)
	);

endmodule
